/* rtl/ngtf_pkg.sv */
package ngtf_pkg;

    // stream and frame constants
    localparam logic [7:0] MAGIC_FIRST  = 8'h16;
    localparam logic [7:0] MAGIC_SECOND = 8'h03;
    localparam logic [7:0] LINE_START   = 8'h24;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam int HEADER_LEN = 6;
    localparam int TIME_LEN   = 6;
    localparam int POS_MAX    = HEADER_LEN + TIME_LEN;
    localparam int FRAME_LEN  = 6;

    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // widest seconds value is 99*3600 + 99*60 + 99 = 362439
    localparam int SEC_W = 19;
    localparam int POS_W = 4;
    localparam int CNT_W = 3;
    localparam int DIG_W = 3;

    typedef logic [3:0] t_digit;

    // request from the line parser to the frame sender
    typedef struct packed {
        logic             fire;
        logic [SEC_W-1:0] seconds;
    } t_frame_req;

    // expected header text "GPGGA,"
    function automatic logic [7:0] header_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h47;
            4'd1:    c = 8'h50;
            4'd2:    c = 8'h47;
            4'd3:    c = 8'h47;
            4'd4:    c = 8'h41;
            4'd5:    c = 8'h2c;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ngtf_rx_if.sv */
interface ngtf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/ngtf_tx_if.sv */
interface ngtf_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

/* rtl/ngtf_parser.sv */
module ngtf_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_one_shot,
    output ngtf_pkg::t_frame_req o_req
);

    logic                          r_started, n_started;
    logic [ngtf_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                          r_hdr_ok, n_hdr_ok;
    logic                          r_dig_ok, n_dig_ok;
    logic                          r_sent, n_sent;
    ngtf_pkg::t_digit              r_digits [ngtf_pkg::TIME_LEN];

    logic                          is_dollar;
    logic                          is_digit;
    logic                          in_header;
    logic                          in_time;
    logic                          dig_we;
    logic [ngtf_pkg::DIG_W-1:0]    dig_idx;
    ngtf_pkg::t_digit              dig_val;
    logic [6:0]                    hours, mins, secs;

    assign is_dollar = (i_byte == ngtf_pkg::LINE_START);
    assign is_digit  = (i_byte inside {[ngtf_pkg::CHAR_ZERO:ngtf_pkg::CHAR_NINE]});
    assign in_header = (r_pos < ngtf_pkg::POS_W'(ngtf_pkg::HEADER_LEN));
    assign in_time   = !in_header && (r_pos < ngtf_pkg::POS_W'(ngtf_pkg::POS_MAX));
    assign dig_idx   = ngtf_pkg::DIG_W'(r_pos - ngtf_pkg::POS_W'(ngtf_pkg::HEADER_LEN));
    assign dig_val   = 4'(i_byte - ngtf_pkg::CHAR_ZERO);
    assign dig_we    = i_accept && !is_dollar && r_started && in_time && is_digit;

    // frame fires at the dollar that closes a complete, valid line, unless one_shot is set and a frame was already sent
    assign o_req.fire = i_accept && is_dollar && r_started && r_hdr_ok && r_dig_ok
                        && (r_pos == ngtf_pkg::POS_W'(ngtf_pkg::POS_MAX))
                        && !(i_one_shot && r_sent);

    // hh mm ss to seconds of day, constant multiplies only
    assign hours = 7'(r_digits[0]) * 7'd10 + 7'(r_digits[1]);
    assign mins  = 7'(r_digits[2]) * 7'd10 + 7'(r_digits[3]);
    assign secs  = 7'(r_digits[4]) * 7'd10 + 7'(r_digits[5]);
    assign o_req.seconds =
        ngtf_pkg::SEC_W'(hours) * ngtf_pkg::SEC_W'(ngtf_pkg::SECS_PER_HOUR)
        + ngtf_pkg::SEC_W'(mins) * ngtf_pkg::SEC_W'(ngtf_pkg::SECS_PER_MIN)
        + ngtf_pkg::SEC_W'(secs);

    // line state update
    always_comb begin
        n_started = r_started;
        n_pos     = r_pos;
        n_hdr_ok  = r_hdr_ok;
        n_dig_ok  = r_dig_ok;
        n_sent    = r_sent;
        if (i_accept) begin
            if (is_dollar) begin
                n_started = 1'b1;
                n_pos     = '0;
                n_hdr_ok  = 1'b1;
                n_dig_ok  = 1'b1;
                if (o_req.fire) begin
                    n_sent = 1'b1;
                end
            end else if (r_started) begin
                if (in_header) begin
                    if (i_byte != ngtf_pkg::header_char(r_pos)) begin
                        n_hdr_ok = 1'b0;
                    end
                end else if (in_time && !is_digit) begin
                    n_dig_ok = 1'b0;
                end
                if (r_pos < ngtf_pkg::POS_W'(ngtf_pkg::POS_MAX)) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_pos     <= '0;
            r_hdr_ok  <= 1'b0;
            r_dig_ok  <= 1'b0;
            r_sent    <= 1'b0;
        end else begin
            r_started <= n_started;
            r_pos     <= n_pos;
            r_hdr_ok  <= n_hdr_ok;
            r_dig_ok  <= n_dig_ok;
            r_sent    <= n_sent;
        end
    end

    // time digit store, one write per accepted digit
    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_digits[dig_idx] <= dig_val;
        end
    end

endmodule

/* rtl/nmea_gpgga_time_to_frame.sv */
// channel | dir | handshake   | payload
// i_rx    | in  | valid/ready | rx_byte[7:0]
// o_tx    | out | valid/ready | tx_byte[7:0], last_byte
// i_cfg   | in  | we only     | i_cfg_data (one_shot)
//
// one received byte per cycle; a byte is parsed in the cycle it is taken
// a closing '$' loads a six byte frame register, first byte visible next cycle
// the frame drains one byte per cycle of o_tx.ready; other bytes keep flowing
// a '$' waits (ready low) only while a previous frame is still draining
// synchronous active-low reset; one_shot resets to 1
module nmea_gpgga_time_to_frame (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ngtf_rx_if.sink       i_rx,
    ngtf_tx_if.source     o_tx,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data
);

    logic                         r_one_shot;
    logic                         r_busy, n_busy;
    logic [ngtf_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [ngtf_pkg::SEC_W-1:0]   r_secs;
    logic [31:0]                  secs_word;
    logic                         rx_accept;
    logic                         tx_accept;
    logic                         is_last;
    ngtf_pkg::t_frame_req         req;

    // a dollar must wait for the frame register to drain
    assign i_rx.ready = !(r_busy && (i_rx.rx_byte == ngtf_pkg::LINE_START));
    assign rx_accept  = i_rx.valid && i_rx.ready;

    ngtf_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (rx_accept),
        .i_byte     (i_rx.rx_byte),
        .i_one_shot (r_one_shot),
        .o_req      (req)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_shot <= 1'b1;
        end else if (i_cfg_we) begin
            r_one_shot <= i_cfg_data;
        end
    end

    // output byte select
    assign secs_word = 32'(r_secs);
    assign is_last   = (r_cnt == ngtf_pkg::CNT_W'(ngtf_pkg::FRAME_LEN - 1));
    assign tx_accept = o_tx.valid && o_tx.ready;

    always_comb begin
        case (r_cnt)
            3'd0:    o_tx.tx_byte = ngtf_pkg::MAGIC_FIRST;
            3'd1:    o_tx.tx_byte = ngtf_pkg::MAGIC_SECOND;
            3'd2:    o_tx.tx_byte = secs_word[7:0];
            3'd3:    o_tx.tx_byte = secs_word[15:8];
            3'd4:    o_tx.tx_byte = secs_word[23:16];
            default: o_tx.tx_byte = secs_word[31:24];
        endcase
    end

    assign o_tx.valid     = r_busy;
    assign o_tx.last_byte = is_last;

    // frame sequencing
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (req.fire) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (tx_accept) begin
            if (is_last) begin
                n_busy = 1'b0;
                n_cnt  = '0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // seconds payload register
    always_ff @(posedge i_clk) begin
        if (req.fire) begin
            r_secs <= req.seconds;
        end
    end

`ifndef SYNTHESIS
    // a frame is never loaded over one still draining
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.fire |-> !r_busy)
        else $error("frame loaded while busy");

    // taking the last byte frees the frame register
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tx_accept && o_tx.last_byte) |=> !r_busy)
        else $error("frame register not freed after last byte");

    // every frame starts with the first magic byte
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (o_tx.tx_byte == ngtf_pkg::MAGIC_FIRST))
        else $error("frame does not start with magic byte");
`endif

endmodule
